### design/sba_pkg.sv
package sba_pkg;

   // geometry
   localparam int MAX_TRACKS        = 255;
   localparam int SECTORS_PER_TRACK = 256;
   localparam int BYTES_PER_TRACK   = SECTORS_PER_TRACK / 8;
   localparam int TRACK_W           = $clog2(MAX_TRACKS + 1);
   localparam int SECTOR_W          = $clog2(SECTORS_PER_TRACK);
   localparam int BYTE_W            = $clog2(BYTES_PER_TRACK);
   localparam int ADDR_W            = TRACK_W + BYTE_W;
   localparam int MEM_DEPTH         = 1 << ADDR_W;
   localparam int COUNT_W           = 16;
   localparam int CMD_W             = 3;
   localparam int STATUS_W          = 2;

   localparam logic [COUNT_W-1:0] RESET_FREE = COUNT_W'(221);

   typedef enum logic [CMD_W-1:0] {
      CMD_FREE  = 3'd0,
      CMD_ALLOC = 3'd1,
      CMD_QUERY = 3'd2,
      CMD_FIND  = 3'd3,
      CMD_COUNT = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_SAME  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MOD,
      ST_RESP,
      ST_SEARCH,
      ST_GROW
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // reset contents of track 1: sectors 0-2 and 16-47 used
   function automatic logic [7:0] init_byte(input logic [BYTE_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx == BYTE_W'(0)) begin
         b = 8'h07;
      end else if (idx >= BYTE_W'(2) && idx <= BYTE_W'(5)) begin
         b = 8'hff;
      end
      return b;
   endfunction

endpackage

### design/sba_bitmap_ram.sv
module sba_bitmap_ram (
   input  logic                   clock,
   input  sba_pkg::ram_wr_type    wr,
   input  sba_pkg::ram_rd_type    rd,
   output logic [7:0]             rd_data
);
   import sba_pkg::*;

   logic [7:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

### design/sector_bitmap_allocator.sv
// channel | dir | beat fields (low bit up)
// req     | in  | tdata: cmd[2:0] track_num[10:3] sector_num[18:11], zero pad to 24
// rsp     | out | tdata: status[1:0] is_free[2] found_track[10:3] found_sector[18:11]
//         |     |        grew[19] free_count[35:20], zero pad to 40
//
// free, allocate and query: bitmap byte read, then modify and write back
// count and bad-address beats: accept, then response
// find reads one bitmap byte per cycle while the rsp register is free;
//   appending a track clears its bytes
// after reset, track 1 is loaded before the first req beat is taken
// a result waits in the rsp register; the next req beat is taken meanwhile, a find
//   walk pauses while that result waits and other work pauses only at its own result
module sector_bitmap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd, track_num, sector_num
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status, is_free, found_track, found_sector, grew, free_count
);
   import sba_pkg::*;

   // control state
   state_type            state_ff, state_in;
   logic [TRACK_W-1:0]   track_count_ff, track_count_in;
   logic [COUNT_W-1:0]   free_ff, free_in;
   logic [BYTE_W-1:0]    cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // search pipeline: issue side and data side
   logic                 issue_on_ff, issue_on_in;
   logic                 first_pend_ff, first_pend_in;
   logic [ADDR_W-1:0]    scan_ff, scan_in;
   logic                 dvalid_ff, dvalid_in;
   logic                 dfirst_ff, dfirst_in;
   logic                 dlast_ff, dlast_in;
   // payload
   logic [ADDR_W-1:0]    dptr_ff, dptr_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [TRACK_W-1:0]   trk_ff, trk_in;
   logic [SECTOR_W-1:0]  sec_ff, sec_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;

   ram_wr_type           ram_wr;
   ram_rd_type           ram_rd;
   logic [7:0]           ram_rdata;

   // request fields
   logic [CMD_W-1:0]     req_cmd;
   logic [TRACK_W-1:0]   req_trk;
   logic [SECTOR_W-1:0]  req_sec;
   logic                 req_fire;
   logic                 req_ok;
   logic                 out_free;

   // derived
   logic [ADDR_W-1:0]    start_addr;
   logic [ADDR_W-1:0]    scan_next;
   logic [TRACK_W-1:0]   scan_trk;
   logic [7:0]           lo_mask;
   logic [7:0]           scan_mask;
   logic [7:0]           free_bits;
   logic                 hit;
   logic [2:0]           hit_idx;
   logic                 cur_bit;
   logic [7:0]           bit_mask;
   logic                 last_byte;

   // lowest set bit of a byte
   function automatic logic [2:0] low_one(input logic [7:0] v);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   // build a response beat
   function automatic logic [39:0] pack_rsp(input status_type st, input logic isf,
                                            input logic [TRACK_W-1:0] ft,
                                            input logic [SECTOR_W-1:0] fs,
                                            input logic gr,
                                            input logic [COUNT_W-1:0] fc);
      return {4'd0, fc, gr, fs, ft, isf, st};
   endfunction

   assign req_cmd  = req_tdata[2:0];
   assign req_trk  = req_tdata[10:3];
   assign req_sec  = req_tdata[18:11];
   assign req_fire = req_tvalid && req_tready;
   assign req_ok   = (req_trk != '0) && (req_trk <= track_count_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // search start byte of the stored command
   assign start_addr = {TRACK_W'(trk_ff - TRACK_W'(1)), sec_ff[SECTOR_W-1:3]};

   // next byte in scan order, wrapping from the last track to track 1
   assign scan_trk = scan_ff[ADDR_W-1:BYTE_W];
   always_comb begin
      if (scan_ff[BYTE_W-1:0] == BYTE_W'(BYTES_PER_TRACK - 1)) begin
         if (scan_trk == TRACK_W'(track_count_ff - TRACK_W'(1))) begin
            scan_next = '0;
         end else begin
            scan_next = {TRACK_W'(scan_trk + TRACK_W'(1)), BYTE_W'(0)};
         end
      end else begin
         scan_next = ADDR_W'(scan_ff + ADDR_W'(1));
      end
   end

   // start byte is seen twice: upper bits first, lower bits on the way back
   assign lo_mask = ~(8'hff << sec_ff[2:0]);
   always_comb begin
      if (dfirst_ff) begin
         scan_mask = ~lo_mask;
      end else if (dlast_ff) begin
         scan_mask = lo_mask;
      end else begin
         scan_mask = 8'hff;
      end
   end
   assign free_bits = ~ram_rdata & scan_mask;
   assign hit       = |free_bits;
   assign hit_idx   = low_one(free_bits);

   assign bit_mask  = 8'h01 << sec_ff[2:0];
   assign cur_bit   = |(ram_rdata & bit_mask);
   assign last_byte = (cnt_ff == BYTE_W'(BYTES_PER_TRACK - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (last_byte) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ok && req_cmd <= CMD_QUERY) begin
                  state_in = ST_MOD;
               end else if (req_ok && req_cmd == CMD_FIND) begin
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_MOD, ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (out_free && dvalid_ff) begin
               if (hit) begin
                  state_in = ST_IDLE;
               end else if (dlast_ff) begin
                  state_in = (track_count_ff < TRACK_W'(MAX_TRACKS)) ? ST_GROW : ST_IDLE;
               end
            end
         end
         ST_GROW: begin
            if (last_byte && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      track_count_in = track_count_ff;
      free_in        = free_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      issue_on_in    = issue_on_ff;
      first_pend_in  = first_pend_ff;
      scan_in        = scan_ff;
      dvalid_in      = dvalid_ff;
      dfirst_in      = dfirst_ff;
      dlast_in       = dlast_ff;
      dptr_in        = dptr_ff;
      cmd_in         = cmd_ff;
      trk_in         = trk_ff;
      sec_in         = sec_ff;
      ram_wr         = '0;
      ram_rd         = '0;

      case (state_ff)
         ST_INIT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = {TRACK_W'(0), cnt_ff};
            ram_wr.data = init_byte(cnt_ff);
            cnt_in      = BYTE_W'(cnt_ff + BYTE_W'(1));
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_cmd;
               trk_in        = req_trk;
               sec_in        = req_sec;
               ram_rd.en     = 1'b1;
               ram_rd.addr   = {TRACK_W'(req_trk - TRACK_W'(1)), req_sec[SECTOR_W-1:3]};
               scan_in       = ram_rd.addr;
               issue_on_in   = 1'b1;
               first_pend_in = 1'b1;
               dvalid_in     = 1'b0;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_rsp((cmd_ff <= CMD_FIND) ? STAT_RANGE : STAT_DONE, 1'b0,
                                       '0, '0, 1'b0, free_ff);
            end
         end
         ST_MOD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  CMD_FREE: begin
                     if (!cur_bit) begin
                        rsp_data_in = pack_rsp(STAT_SAME, 1'b0, '0, '0, 1'b0, free_ff);
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = start_addr;
                        ram_wr.data = ram_rdata & ~bit_mask;
                        free_in     = COUNT_W'(free_ff + COUNT_W'(1));
                        rsp_data_in = pack_rsp(STAT_DONE, 1'b0, '0, '0, 1'b0, free_in);
                     end
                  end
                  CMD_ALLOC: begin
                     if (cur_bit) begin
                        rsp_data_in = pack_rsp(STAT_SAME, 1'b0, '0, '0, 1'b0, free_ff);
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = start_addr;
                        ram_wr.data = ram_rdata | bit_mask;
                        free_in     = COUNT_W'(free_ff - COUNT_W'(1));
                        rsp_data_in = pack_rsp(STAT_DONE, 1'b0, '0, '0, 1'b0, free_in);
                     end
                  end
                  default: begin
                     rsp_data_in = pack_rsp(STAT_DONE, !cur_bit, '0, '0, 1'b0, free_ff);
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (out_free) begin
               // issue side: one byte read a cycle while the rsp register is free
               if (issue_on_ff) begin
                  ram_rd.en     = 1'b1;
                  ram_rd.addr   = scan_ff;
                  dvalid_in     = 1'b1;
                  dptr_in       = scan_ff;
                  dfirst_in     = first_pend_ff;
                  dlast_in      = !first_pend_ff && (scan_ff == start_addr);
                  first_pend_in = 1'b0;
                  scan_in       = scan_next;
                  if (dlast_in) begin
                     issue_on_in = 1'b0;
                  end
               end else begin
                  dvalid_in = 1'b0;
               end
               // data side
               if (dvalid_ff) begin
                  if (hit) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(STAT_DONE, 1'b0,
                                             TRACK_W'(dptr_ff[ADDR_W-1:BYTE_W] + TRACK_W'(1)),
                                             {dptr_ff[BYTE_W-1:0], hit_idx}, 1'b0, free_ff);
                  end else if (dlast_ff) begin
                     if (track_count_ff < TRACK_W'(MAX_TRACKS)) begin
                        cnt_in = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = pack_rsp(STAT_SAME, 1'b0, '0, '0, 1'b0, free_ff);
                     end
                  end
                  if (hit || dlast_ff) begin
                     issue_on_in = 1'b0;
                     dvalid_in   = 1'b0;
                  end
               end
            end
         end
         ST_GROW: begin
            // clear the bytes of the appended track
            if (!last_byte || out_free) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = {track_count_ff, cnt_ff};
               ram_wr.data = 8'h00;
               cnt_in      = BYTE_W'(cnt_ff + BYTE_W'(1));
               if (last_byte) begin
                  track_count_in = TRACK_W'(track_count_ff + TRACK_W'(1));
                  free_in        = COUNT_W'(free_ff + COUNT_W'(SECTORS_PER_TRACK));
                  rsp_valid_in   = 1'b1;
                  rsp_data_in    = pack_rsp(STAT_DONE, 1'b0, track_count_in, '0, 1'b1,
                                            free_in);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         track_count_ff <= TRACK_W'(1);
         free_ff        <= RESET_FREE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         issue_on_ff    <= 1'b0;
         first_pend_ff  <= 1'b0;
         dvalid_ff      <= 1'b0;
         dfirst_ff      <= 1'b0;
         dlast_ff       <= 1'b0;
         scan_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         track_count_ff <= track_count_in;
         free_ff        <= free_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         issue_on_ff    <= issue_on_in;
         first_pend_ff  <= first_pend_in;
         dvalid_ff      <= dvalid_in;
         dfirst_ff      <= dfirst_in;
         dlast_ff       <= dlast_in;
         scan_ff        <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      dptr_ff     <= dptr_in;
      cmd_ff      <= cmd_in;
      trk_ff      <= trk_in;
      sec_ff      <= sec_in;
      rsp_data_ff <= rsp_data_in;
   end

   sba_bitmap_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rdata)
   );

endmodule
